// ===== hw/rtl/hsj_pkg.sv =====
// Shared types and constants for the 3D heat stencil core.
package hsj_pkg;

    localparam int MAX_SIDE  = 32;
    localparam int FRAC_BITS = 30;

    localparam int CFG_DW  = 31;
    localparam int CFG_IW  = 3;
    localparam int CNT_W   = 20;
    localparam int COEF_W  = 16;
    localparam int EXT_W   = 6;
    localparam int CRD_W   = 5;
    localparam int OP_W    = 2;
    localparam int THR_W   = 31;
    localparam int COEF_SH = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_SWEEP = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [CFG_IW-1:0] {
        CFG_COEF  = 3'd0,
        CFG_THR   = 3'd1,
        CFG_LIMIT = 3'd2,
        CFG_EXT_X = 3'd3,
        CFG_EXT_Y = 3'd4,
        CFG_EXT_Z = 3'd5,
        CFG_SPARE6 = 3'd6,
        CFG_SPARE7 = 3'd7
    } t_cfg_idx;

    localparam logic [COEF_W-1:0] COEF_RST  = 16'd6554;
    localparam logic [THR_W-1:0]  THR_RST   = 31'd107374;
    localparam logic [CNT_W-1:0]  LIMIT_RST = 20'd10000;
    localparam logic [EXT_W-1:0]  EXT_RST   = 6'd32;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_INIT = 8'b0000_0010,
        S_RDA  = 8'b0000_0100,
        S_RDD  = 8'b0000_1000,
        S_SWP  = 8'b0001_0000,
        S_CPY  = 8'b0010_0000,
        S_CFL  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

endpackage

// ===== hw/rtl/hsj_in_if.sv =====
// Request channel carrying one operation word.
interface hsj_in_if;
    import hsj_pkg::*;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [CRD_W-1:0] coord_x;
    logic [CRD_W-1:0] coord_y;
    logic [CRD_W-1:0] coord_z;
    modport source (output valid, operation, coord_x, coord_y, coord_z, input ready);
    modport sink (input valid, operation, coord_x, coord_y, coord_z, output ready);
endinterface

// ===== hw/rtl/hsj_out_if.sv =====
// Result channel carrying one status word.
interface hsj_out_if;
    import hsj_pkg::*;
    logic               valid;
    logic               ready;
    logic [CNT_W-1:0]   sweeps_done;
    logic [FRAC_BITS:0] max_change;
    logic               converged;
    logic [FRAC_BITS:0] cell_value;
    logic               coord_bad;
    modport source (output valid, sweeps_done, max_change, converged, cell_value, coord_bad,
                    input ready);
    modport sink (input valid, sweeps_done, max_change, converged, cell_value, coord_bad,
                  output ready);
endinterface

// ===== hw/rtl/hsj_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module hsj_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/heat_stencil_3d_jacobi_core.sv =====
// Top level of the 3D Jacobi heat stencil core with grid and scratch memories.
//
//  channel   direction  words
//  i_in      in         operation, coord_x, coord_y, coord_z
//  o_out     out        sweeps_done, max_change, converged, cell_value, coord_bad
//  i_cfg_*   in         register index and data, written while i_cfg_we is high
//
// Each word is taken only when the core is idle and gives exactly one result.
// A read passes through S_RDA and S_RDD before S_OUT registers its result; any other word
// that touches no grid entry goes straight to S_OUT. The core is ready for the next word in
// the same cycle that the result appears. A sweep steps through phases per interior point
// (seven reads of the single grid read port, then multiply and write to scratch), then copies
// every interior point back. Initialisation, and the pass after reset, writes every grid
// entry once. A held result stalls only the S_OUT step of the next word.
module heat_stencil_3d_jacobi_core
    import hsj_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    hsj_in_if.sink            i_in,
    hsj_out_if.source         o_out
);
    localparam int W     = FRAC_BITS + 1;
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int UW    = (CW + 2 > EXT_W) ? CW + 2 : EXT_W;
    localparam int TW    = (W > THR_W) ? W : THR_W;
    localparam int SW    = W + 3;
    localparam int LW    = W + 4;
    localparam int PW    = LW + COEF_W + 1;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    t_state r_state;
    logic [3:0] r_ph;
    logic [CW-1:0] r_x, r_y, r_z;
    logic [AW:0] r_fill;
    logic r_boot;
    logic [W-1:0] r_c;
    logic [SW-1:0] r_sum;
    logic signed [PW-1:0] r_prod;
    logic [W-1:0] r_res, r_max, r_cell;
    logic r_known, r_bad, r_wv;
    logic [CNT_W-1:0] r_count;
    logic [AW-1:0] r_wa;
    logic [COEF_W-1:0] r_coef;
    logic [THR_W-1:0] r_thr;
    logic [CNT_W-1:0] r_lim;
    logic [EXT_W-1:0] r_ex, r_ey, r_ez;
    logic r_ov;
    logic [CNT_W-1:0] r_o_cnt;
    logic [W-1:0] r_o_max, r_o_cell;
    logic r_o_conv, r_o_bad;

    logic [UW-1:0] w_ux, w_uy, w_uz;
    logic w_stop, w_empty, w_xl, w_yl, w_zl, w_last, w_bad_rd;
    logic [AW-1:0] w_cur, w_graddr;
    logic [CW-1:0] w_nx, w_ny, w_nz;
    logic [W-1:0] w_grd, w_srd, w_gwd, w_v, w_d;
    logic w_gwe;
    logic [AW-1:0] w_gwa;
    logic signed [LW-1:0] w_lap;
    logic signed [COEF_W:0] w_k;
    logic signed [PW-1:0] w_delta, w_vs;

    function automatic logic [UW-1:0] used_ext(input logic [EXT_W-1:0] e);
        return (UW'(e) > UW'(MAX_SIDE)) ? UW'(MAX_SIDE) : UW'(e);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
        return {x, y, z};
    endfunction

    assign w_ux = used_ext(r_ex);
    assign w_uy = used_ext(r_ey);
    assign w_uz = used_ext(r_ez);
    assign w_stop = (r_count >= r_lim) || (r_known && (TW'(r_res) <= TW'(r_thr)));
    assign w_empty = (w_ux < UW'(3)) || (w_uy < UW'(3)) || (w_uz < UW'(3));
    assign w_bad_rd = (UW'(i_in.coord_x) >= w_ux) || (UW'(i_in.coord_y) >= w_uy) ||
                      (UW'(i_in.coord_z) >= w_uz);

    assign w_xl = (UW'(r_x) + UW'(2)) >= w_ux;
    assign w_yl = (UW'(r_y) + UW'(2)) >= w_uy;
    assign w_zl = (UW'(r_z) + UW'(2)) >= w_uz;
    assign w_last = w_xl && w_yl && w_zl;
    assign w_cur = addr_of(r_x, r_y, r_z);

    always_comb begin
        w_nx = r_x;
        w_ny = r_y;
        w_nz = r_z + CW'(1);
        if (w_zl) begin
            w_nz = CW'(1);
            w_ny = r_y + CW'(1);
            if (w_yl) begin
                w_ny = CW'(1);
                w_nx = r_x + CW'(1);
            end
        end
    end

    always_comb begin
        case (r_ph)
            4'd1:    w_graddr = addr_of(r_x + CW'(1), r_y, r_z);
            4'd2:    w_graddr = addr_of(r_x - CW'(1), r_y, r_z);
            4'd3:    w_graddr = addr_of(r_x, r_y + CW'(1), r_z);
            4'd4:    w_graddr = addr_of(r_x, r_y - CW'(1), r_z);
            4'd5:    w_graddr = addr_of(r_x, r_y, r_z + CW'(1));
            4'd6:    w_graddr = addr_of(r_x, r_y, r_z - CW'(1));
            default: w_graddr = w_cur;
        endcase
    end

    assign w_lap = $signed(LW'(r_sum)) - $signed(LW'(r_c) * LW'(6));
    assign w_k = $signed({1'b0, r_coef});
    assign w_delta = r_prod >>> COEF_SH;
    assign w_vs = $signed(PW'(r_c)) + w_delta;

    always_comb begin
        if (w_vs < 0) begin
            w_v = '0;
        end else if (w_vs > $signed(PW'(ONE))) begin
            w_v = ONE;
        end else begin
            w_v = W'(w_vs);
        end
        w_d = (w_v > r_c) ? (w_v - r_c) : (r_c - w_v);
    end

    always_comb begin
        if (r_state == S_INIT) begin
            w_gwe = 1'b1;
            w_gwa = r_fill[AW-1:0];
            w_gwd = (r_fill[AW-1 -: CW] == '0) ? ONE : '0;
        end else begin
            w_gwe = r_wv;
            w_gwa = r_wa;
            w_gwd = w_srd;
        end
    end

    hsj_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_gwe),
        .i_waddr (w_gwa),
        .i_wdata (w_gwd),
        .i_raddr (w_graddr),
        .o_rdata (w_grd)
    );

    hsj_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_scratch (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_SWP) && (r_ph == 4'd9)),
        .i_waddr (w_cur),
        .i_wdata (w_v),
        .i_raddr (w_cur),
        .o_rdata (w_srd)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.sweeps_done = r_o_cnt;
    assign o_out.max_change = r_o_max;
    assign o_out.converged = r_o_conv;
    assign o_out.cell_value = r_o_cell;
    assign o_out.coord_bad = r_o_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RST;
            r_thr <= THR_RST;
            r_lim <= LIMIT_RST;
            r_ex <= EXT_RST;
            r_ey <= EXT_RST;
            r_ez <= EXT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COEF:  r_coef <= i_cfg_data[COEF_W-1:0];
                CFG_THR:   r_thr <= i_cfg_data[THR_W-1:0];
                CFG_LIMIT: r_lim <= i_cfg_data[CNT_W-1:0];
                CFG_EXT_X: r_ex <= i_cfg_data[EXT_W-1:0];
                CFG_EXT_Y: r_ey <= i_cfg_data[EXT_W-1:0];
                CFG_EXT_Z: r_ez <= i_cfg_data[EXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa <= w_cur;
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ph <= '0;
            r_fill <= '0;
            r_boot <= 1'b1;
            r_count <= '0;
            r_known <= 1'b0;
            r_ov <= 1'b0;
            r_wv <= 1'b0;
        end else begin
            r_wv <= (r_state == S_CPY);
            if (r_ov && o_out.ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cell <= '0;
                        r_bad <= 1'b0;
                        case (t_op'(i_in.operation))
                            OP_INIT: begin
                                r_fill <= '0;
                                r_boot <= 1'b0;
                                r_state <= S_INIT;
                            end
                            OP_SWEEP: begin
                                if (!w_stop && w_empty) begin
                                    r_res <= '0;
                                    r_known <= 1'b1;
                                    r_count <= r_count + CNT_W'(1);
                                    r_state <= S_OUT;
                                end else if (!w_stop) begin
                                    r_x <= CW'(1);
                                    r_y <= CW'(1);
                                    r_z <= CW'(1);
                                    r_ph <= '0;
                                    r_max <= '0;
                                    r_state <= S_SWP;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            OP_READ: begin
                                r_x <= CW'(i_in.coord_x);
                                r_y <= CW'(i_in.coord_y);
                                r_z <= CW'(i_in.coord_z);
                                if (w_bad_rd) begin
                                    r_bad <= 1'b1;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_RDA;
                                end
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    r_fill <= r_fill + (AW + 1)'(1);
                    if (r_fill == (AW + 1)'(DEPTH - 1)) begin
                        r_count <= '0;
                        r_known <= 1'b0;
                        r_state <= r_boot ? S_IDLE : S_OUT;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDD;
                end
                S_RDD: begin
                    r_cell <= w_grd;
                    r_state <= S_OUT;
                end
                S_SWP: begin
                    r_ph <= (r_ph == 4'd9) ? 4'd0 : r_ph + 4'd1;
                    if (r_ph == 4'd1) begin
                        r_c <= w_grd;
                    end else if (r_ph == 4'd2) begin
                        r_sum <= SW'(w_grd);
                    end else if (r_ph > 4'd2 && r_ph < 4'd8) begin
                        r_sum <= r_sum + SW'(w_grd);
                    end else if (r_ph == 4'd8) begin
                        r_prod <= w_k * w_lap;
                    end else if (r_ph == 4'd9) begin
                        if (w_d > r_max) begin
                            r_max <= w_d;
                        end
                        if (w_last) begin
                            r_x <= CW'(1);
                            r_y <= CW'(1);
                            r_z <= CW'(1);
                            r_state <= S_CPY;
                        end else begin
                            r_x <= w_nx;
                            r_y <= w_ny;
                            r_z <= w_nz;
                        end
                    end
                end
                S_CPY: begin
                    r_x <= w_nx;
                    r_y <= w_ny;
                    r_z <= w_nz;
                    if (w_last) begin
                        r_state <= S_CFL;
                    end
                end
                S_CFL: begin
                    r_res <= r_max;
                    r_known <= 1'b1;
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov <= 1'b1;
                        r_o_cnt <= r_count;
                        r_o_max <= r_known ? r_res : ONE;
                        r_o_conv <= w_stop;
                        r_o_cell <= r_cell;
                        r_o_bad <= r_bad;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== tb/heat_grid_checker.sv =====
// Checker that predicts every status word of the heat stencil core and compares it.
module heat_grid_checker
    import hsj_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    hsj_in_if                 heat_in,
    hsj_out_if                heat_out,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int SIDE = 32;
    localparam longint ONE = longint'(1) << 30;

    typedef struct packed {
        logic [CNT_W-1:0] sweeps;
        logic [30:0]      change;
        logic             conv;
        logic [30:0]      cell_v;
        logic             bad;
    } t_status;

    logic [30:0]      grid [SIDE*SIDE*SIDE];
    logic [30:0]      scratch [SIDE*SIDE*SIDE];
    logic [30:0]      residual;
    logic             residual_known;
    logic [CNT_W-1:0] sweep_count;

    logic [COEF_W-1:0] coef;
    logic [THR_W-1:0]  thr;
    logic [CNT_W-1:0]  limit;
    logic [EXT_W-1:0]  ext [3];

    t_status expected_status [$];
    int      fails;
    int      pend;

    assign o_fail_count = fails;
    assign o_pending    = pend;

    function automatic int used(logic [EXT_W-1:0] e);
        return (e > SIDE) ? SIDE : int'(e);
    endfunction

    function automatic int at(int x, int y, int z);
        return (x * SIDE + y) * SIDE + z;
    endfunction

    function automatic void fill_grid();
        for (int i = 0; i < SIDE*SIDE*SIDE; i++) begin
            grid[i] = (i < SIDE*SIDE) ? 31'(ONE) : 31'd0;
        end
        sweep_count    = '0;
        residual       = '0;
        residual_known = 1'b0;
    endfunction

    function automatic logic halted();
        return (sweep_count >= limit) || (residual_known && residual <= thr);
    endfunction

    function automatic void jacobi_sweep();
        int ex, ey, ez, i;
        longint c, lap, v, d, res;
        ex = used(ext[0]);
        ey = used(ext[1]);
        ez = used(ext[2]);
        res = 0;
        for (int x = 1; x + 1 < ex; x++)
            for (int y = 1; y + 1 < ey; y++)
                for (int z = 1; z + 1 < ez; z++) begin
                    i = at(x, y, z);
                    c = longint'(grid[i]);
                    lap = longint'(grid[i+SIDE*SIDE]) + longint'(grid[i-SIDE*SIDE])
                        + longint'(grid[i+SIDE]) + longint'(grid[i-SIDE])
                        + longint'(grid[i+1]) + longint'(grid[i-1]) - 6 * c;
                    v = c + ((longint'(coef) * lap) >>> COEF_SH);
                    if (v < 0) v = 0;
                    if (v > ONE) v = ONE;
                    scratch[i] = 31'(v);
                    d = (v > c) ? v - c : c - v;
                    if (d > res) res = d;
                end
        for (int x = 1; x + 1 < ex; x++)
            for (int y = 1; y + 1 < ey; y++)
                for (int z = 1; z + 1 < ez; z++) begin
                    grid[at(x, y, z)] = scratch[at(x, y, z)];
                end
        residual       = 31'(res);
        residual_known = 1'b1;
        sweep_count    = sweep_count + 1'b1;
    endfunction

    function automatic t_status predict_status(t_op op, int x, int y, int z);
        t_status s;
        s = '0;
        case (op)
            OP_INIT: begin
                fill_grid();
            end
            OP_SWEEP: begin
                if (!halted()) jacobi_sweep();
            end
            OP_READ: begin
                if (x >= used(ext[0]) || y >= used(ext[1]) || z >= used(ext[2])) begin
                    s.bad = 1'b1;
                end else begin
                    s.cell_v = grid[at(x, y, z)];
                end
            end
            default: begin
            end
        endcase
        s.sweeps = sweep_count;
        s.change = residual_known ? residual : 31'(ONE);
        s.conv   = halted();
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_status got, want;
        if (!i_rst_n) begin
            coef  <= COEF_RST;
            thr   <= THR_RST;
            limit <= LIMIT_RST;
            ext   <= '{EXT_RST, EXT_RST, EXT_RST};
            fill_grid();
            expected_status.delete();
            fails = 0;
            pend  = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_COEF:  coef   <= i_cfg_data[COEF_W-1:0];
                    CFG_THR:   thr    <= i_cfg_data[THR_W-1:0];
                    CFG_LIMIT: limit  <= i_cfg_data[CNT_W-1:0];
                    CFG_EXT_X: ext[0] <= i_cfg_data[EXT_W-1:0];
                    CFG_EXT_Y: ext[1] <= i_cfg_data[EXT_W-1:0];
                    CFG_EXT_Z: ext[2] <= i_cfg_data[EXT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (heat_out.valid && heat_out.ready) begin
                got = '{heat_out.sweeps_done, heat_out.max_change, heat_out.converged,
                        heat_out.cell_value, heat_out.coord_bad};
                if (expected_status.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("Unexpected word: %p", got);
                end else begin
                    want = expected_status.pop_front();
                    if (got.sweeps !== want.sweeps || got.change !== want.change ||
                        got.conv !== want.conv || got.cell_v !== want.cell_v ||
                        got.bad !== want.bad) begin
                        fails++;
                        if (fails <= 10)
                            $display("Mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (heat_in.valid && heat_in.ready) begin
                expected_status.push_back(predict_status(t_op'(heat_in.operation),
                    int'(heat_in.coord_x), int'(heat_in.coord_y), int'(heat_in.coord_z)));
            end
            pend = expected_status.size();
        end
    end

    final begin
        if (expected_status.size() != 0)
            fails++;
    end

endmodule

// ===== tb/heat_stencil_3d_jacobi_core_test.sv =====
// Stimulus, handshake pacing and verdict for the heat stencil core.
module heat_stencil_3d_jacobi_core_test;
    import hsj_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;
    int                fail_count;
    int                pending;
    int                send_idle;
    int                take_idle;
    bit                hold_request;
    int                hold_left;
    int                cycles;
    int                cur_ext [3];

    hsj_in_if  heat_in ();
    hsj_out_if heat_out ();

    heat_stencil_3d_jacobi_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (heat_in),
        .o_out      (heat_out)
    );

    heat_grid_checker grid_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .heat_in      (heat_in),
        .heat_out     (heat_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        heat_in.valid = 1'b0;
        heat_in.operation = '0;
        heat_in.coord_x = '0;
        heat_in.coord_y = '0;
        heat_in.coord_z = '0;
        heat_out.ready = 1'b0;
        send_idle = 14;
        take_idle = 51;
        hold_request = 1'b0;
        hold_left = 0;
        cycles = 0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            heat_out.ready <= 1'b0;
        end else begin
            heat_out.ready <= ($urandom_range(99) >= take_idle);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DW-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_EXT_X: cur_ext[0] = int'(value[EXT_W-1:0]);
            CFG_EXT_Y: cur_ext[1] = int'(value[EXT_W-1:0]);
            CFG_EXT_Z: cur_ext[2] = int'(value[EXT_W-1:0]);
            default: begin
            end
        endcase
    endtask

    task automatic send(t_op op, int x, int y, int z);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            heat_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        heat_in.valid     <= 1'b1;
        heat_in.operation <= op;
        heat_in.coord_x   <= CRD_W'(x);
        heat_in.coord_y   <= CRD_W'(y);
        heat_in.coord_z   <= CRD_W'(z);
        do @(posedge i_clk); while (!heat_in.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        heat_in.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    function automatic int inside_coord(int e);
        int lim;
        lim = (e > 32) ? 32 : e;
        return (lim == 0) ? 0 : $urandom_range(lim - 1);
    endfunction

    task automatic random_setup();
        int big;
        big = $urandom_range(3);
        for (int a = 0; a < 3; a++) begin
            int e;
            int r;
            r = $urandom_range(9);
            if (a == big) e = $urandom_range(63, 20);
            else if (r == 0) e = $urandom_range(2);
            else e = $urandom_range(7, 3);
            write_reg(t_cfg_idx'(CFG_EXT_X + a), CFG_DW'(e));
        end
        case ($urandom_range(3))
            0: write_reg(CFG_COEF, 31'd65535);
            1: write_reg(CFG_COEF, 31'd0);
            default: write_reg(CFG_COEF, CFG_DW'($urandom_range(65535)));
        endcase
        case ($urandom_range(3))
            0: write_reg(CFG_THR, 31'd0);
            1: write_reg(CFG_THR, 31'h4000_0000);
            default: write_reg(CFG_THR, CFG_DW'($urandom_range(1 << 22)));
        endcase
        if ($urandom_range(4) == 0) write_reg(CFG_LIMIT, 31'hFFFFF);
        else write_reg(CFG_LIMIT, CFG_DW'($urandom_range(12)));
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            send(OP_INIT, $urandom_range(31), $urandom_range(31), $urandom_range(31));
        end else if (r < 54) begin
            send(OP_SWEEP, $urandom_range(31), $urandom_range(31), $urandom_range(31));
        end else if (r < 94) begin
            if ($urandom_range(9) < 7)
                send(OP_READ, inside_coord(cur_ext[0]), inside_coord(cur_ext[1]),
                     inside_coord(cur_ext[2]));
            else
                send(OP_READ, $urandom_range(31), $urandom_range(31), $urandom_range(31));
        end else begin
            send(OP_NONE, $urandom_range(31), $urandom_range(31), $urandom_range(31));
        end
    endtask

    initial begin
        cur_ext = '{32, 32, 32};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(OP_READ, 0, 0, 0);
        send(OP_READ, 1, 0, 0);
        send(OP_READ, 31, 31, 31);
        send(OP_NONE, 31, 31, 31);
        send(OP_SWEEP, 0, 0, 0);
        send(OP_READ, 1, 1, 1);
        drain();

        write_reg(CFG_EXT_X, 31'd3);
        write_reg(CFG_EXT_Y, 31'd3);
        write_reg(CFG_EXT_Z, 31'd3);
        write_reg(CFG_COEF, 31'd65535);
        write_reg(CFG_THR, 31'd0);
        write_reg(CFG_LIMIT, 31'd2);
        write_reg(t_cfg_idx'(CFG_SPARE6), 31'h7FFF_FFFF);
        write_reg(t_cfg_idx'(CFG_SPARE7), 31'd1);
        send(OP_INIT, 0, 0, 0);
        send(OP_SWEEP, 0, 0, 0);
        send(OP_READ, 1, 1, 1);
        send(OP_SWEEP, 0, 0, 0);
        send(OP_SWEEP, 0, 0, 0);
        send(OP_READ, 3, 0, 0);
        send(OP_READ, 0, 3, 2);
        send(OP_READ, 2, 2, 3);
        drain();

        write_reg(CFG_EXT_X, 31'd63);
        write_reg(CFG_EXT_Y, 31'd0);
        write_reg(CFG_EXT_Z, 31'd2);
        write_reg(CFG_LIMIT, 31'hFFFFF);
        write_reg(CFG_THR, 31'h4000_0000);
        send(OP_INIT, 31, 31, 31);
        send(OP_SWEEP, 0, 0, 0);
        send(OP_SWEEP, 0, 0, 0);
        send(OP_READ, 31, 0, 0);
        send(OP_READ, 0, 0, 1);
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 14 : (mode == 1) ? 51 : 0;
            take_idle = (mode == 0) ? 51 : (mode == 1) ? 14 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                random_setup();
                if (mode == 0 && blk == 1) hold_request = 1'b1;
                if ($urandom_range(1) == 0)
                    send(OP_INIT, 0, 0, 0);
                for (int n = 0; n < 11; n++) random_item();
                drain();
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
